// ===== hdl/crc_pkg.sv =====
// Package: shared types, constants and tables for the running centroid block.
package crc_pkg;

   localparam int MAX_MEMBERS_DEF  = 64;
   localparam int CORDIC_STEPS_DEF = 16;
   localparam int ATAN_LEN         = 24;
   localparam int AW               = 40;   // CORDIC datapath width

   localparam logic signed [AW-1:0] PI_Q24      = AW'(52707179);
   localparam logic signed [AW-1:0] HALF_PI_Q24 = AW'(26353589);
   localparam logic signed [AW-1:0] UNIT_Q28    = AW'(268435456);
   localparam logic signed [15:0]   HEAD_LIM    = 16'sd25736;

   typedef enum logic [1:0] {
      OP_ADD   = 2'd0,
      OP_QUERY = 2'd1,
      OP_CLEAR = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_FOUND = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic [1:0]         operation;
      logic [15:0]        item_id;
      logic signed [31:0] item_x;
      logic signed [31:0] item_y;
      logic signed [31:0] item_z;
      logic signed [15:0] item_orientation;
      logic               item_dwell;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [6:0]         member_count;
      logic [15:0]        cluster_id;
      logic signed [31:0] mean_x;
      logic signed [31:0] mean_y;
      logic signed [31:0] mean_z;
      logic [15:0]        mean_dwell;
      logic signed [15:0] mean_orientation;
      logic signed [31:0] found_x;
      logic signed [31:0] found_y;
      logic signed [31:0] found_z;
      logic signed [15:0] found_orientation;
   } rsp_type;

   // controller -> datapath commands
   typedef struct packed {
      logic load;        // capture request
      logic first_set;   // first member: set means directly
      logic div_start;   // start the divider
      logic rot_start;   // start rotation of element (sel)
      logic rot_sel;     // 0 mean heading, 1 new heading
      logic acc_load;    // form weighted sums
      logic vec_start;   // start vectoring
      logic mean_upd;    // commit means
      logic store_wr;    // write member entry
      logic scan_rd;     // issue read at scan index
      logic scan_clr;    // reset scan index
      logic found_cap;   // capture found entry
      logic clear;       // empty the store
      logic rsp_load;    // form result word
      logic [1:0] status;
   } cmd_type;

   typedef struct packed {
      logic       div_done;
      logic       rot_done;
      logic       vec_done;
      logic       count_zero;
      logic       full;
      logic       scan_end;   // scan index reached count
      logic       id_match;   // registered read matches
   } sts_type;

   function automatic logic signed [AW-1:0] atan_q24(input int i);
      logic signed [AW-1:0] r;
      case (i)
         0: r = AW'(13176795);  1: r = AW'(7778716);   2: r = AW'(4110060);
         3: r = AW'(2086331);   4: r = AW'(1047214);   5: r = AW'(524117);
         6: r = AW'(262123);    7: r = AW'(131069);    8: r = AW'(65536);
         9: r = AW'(32768);     10: r = AW'(16384);    11: r = AW'(8192);
         12: r = AW'(4096);     13: r = AW'(2048);     14: r = AW'(1024);
         15: r = AW'(512);      16: r = AW'(256);      17: r = AW'(128);
         18: r = AW'(64);       19: r = AW'(32);       20: r = AW'(16);
         21: r = AW'(8);        22: r = AW'(4);        23: r = AW'(2);
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

// ===== hdl/crc_if.sv =====
// Interface: valid/ready channel carrying one word of a given type.
interface crc_if #(parameter type word_type = logic) ();
   logic     valid;
   logic     ready;
   word_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/crc_div.sv =====
// Radix-2 restoring divider: signed dividend by small positive divisor, truncating.
module crc_div import crc_pkg::*; #(
   parameter int NW = 49,
   parameter int DW = 11
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic signed [NW-1:0] dividend,
   input  logic [DW-1:0]        divisor,
   output logic                 done,
   output logic signed [NW-1:0] quotient
);
   localparam int CW = $clog2(NW + 1);

   logic [NW-1:0] q_ff, q_in;
   logic [DW:0]   r_ff, r_in;
   logic [DW-1:0] d_ff;
   logic          neg_ff;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in, done_ff, done_in;
   logic [DW:0]   trial;
   logic [DW:0]   shifted;

   always_comb begin
      shifted = {r_ff[DW-1:0], q_ff[NW-1]};
      trial   = shifted - {1'b0, d_ff};
      q_in    = q_ff;
      r_in    = r_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (busy_ff) begin
         if (!trial[DW]) begin
            r_in = trial;
            q_in = {q_ff[NW-2:0], 1'b1};
         end else begin
            r_in = shifted;
            q_in = {q_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= done_in;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(NW);
         end else begin
            busy_ff <= busy_in;
            cnt_ff  <= cnt_in;
         end
      end
      if (start) begin
         neg_ff <= dividend[NW-1];
         q_ff   <= dividend[NW-1] ? NW'(-dividend) : dividend;
         r_ff   <= '0;
         d_ff   <= divisor;
      end else begin
         q_ff <= q_in;
         r_ff <= r_in;
      end
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? -$signed(q_ff) : $signed(q_ff);
endmodule

// ===== hdl/crc_cordic.sv =====
// Iterative CORDIC: rotation (cos/sin of a heading) or vectoring (atan2).
module crc_cordic import crc_pkg::*; #(
   parameter int STEPS = CORDIC_STEPS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 rot_start,
   input  logic signed [15:0]   heading,
   input  logic                 vec_start,
   input  logic signed [AW-1:0] vx,
   input  logic signed [AW-1:0] vy,
   output logic                 done,
   output logic signed [AW-1:0] cos_out,
   output logic signed [AW-1:0] sin_out,
   output logic signed [15:0]   angle
);
   localparam int NS = (STEPS > ATAN_LEN) ? ATAN_LEN : STEPS;
   localparam int IW = $clog2(ATAN_LEN + 1);

   logic signed [AW-1:0] x_ff, y_ff, z_ff;
   logic                 flip_ff, vmode_ff, zero_ff;
   logic [IW-1:0]        i_ff;
   logic                 busy_ff, done_ff;
   logic signed [AW-1:0] dx, dy, x_in, y_in, z_in, z0, zr;
   logic                 dir_up;
   logic signed [AW-1:0] zs;
   logic signed [AW-1:0] zsat;

   always_comb begin
      dx     = y_ff >>> i_ff;
      dy     = x_ff >>> i_ff;
      dir_up = vmode_ff ? (y_ff <= 0) : (z_ff >= 0);
      if (dir_up) begin
         x_in = x_ff - dx;
         y_in = y_ff + dy;
         z_in = z_ff - atan_q24(int'(i_ff));
      end else begin
         x_in = x_ff + dx;
         y_in = y_ff - dy;
         z_in = z_ff + atan_q24(int'(i_ff));
      end
      z0 = AW'(heading) <<< 11;
      zr = z0;
      if (z0 > HALF_PI_Q24)       zr = z0 - PI_Q24;
      else if (z0 < -HALF_PI_Q24) zr = z0 + PI_Q24;
      zs = (z_ff + AW'(1024)) >>> 11;
      if (zs > AW'(HEAD_LIM))       zsat = AW'(HEAD_LIM);
      else if (zs < -AW'(HEAD_LIM)) zsat = -AW'(HEAD_LIM);
      else                          zsat = zs;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         i_ff    <= '0;
      end else begin
         done_ff <= 1'b0;
         if (rot_start || vec_start) begin
            busy_ff <= (NS != 0) && !(vec_start && vx == 0 && vy == 0);
            done_ff <= (NS == 0) || (vec_start && vx == 0 && vy == 0);
            i_ff    <= '0;
         end else if (busy_ff) begin
            i_ff <= i_ff + 1'b1;
            if (i_ff == IW'(NS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
      if (rot_start) begin
         vmode_ff <= 1'b0;
         zero_ff  <= 1'b0;
         x_ff     <= UNIT_Q28;
         y_ff     <= '0;
         z_ff     <= zr;
         flip_ff  <= (z0 > HALF_PI_Q24) || (z0 < -HALF_PI_Q24);
      end else if (vec_start) begin
         vmode_ff <= 1'b1;
         zero_ff  <= (vx == 0) && (vy == 0);
         flip_ff  <= 1'b0;
         if (vx < 0) begin
            x_ff <= -vx;
            y_ff <= -vy;
            z_ff <= (vy >= 0) ? PI_Q24 : -PI_Q24;
         end else begin
            x_ff <= vx;
            y_ff <= vy;
            z_ff <= '0;
         end
      end else if (busy_ff) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
   end

   assign done    = done_ff;
   assign cos_out = flip_ff ? -x_ff : x_ff;
   assign sin_out = flip_ff ? -y_ff : y_ff;
   assign angle   = zero_ff ? 16'sd0 : zsat[15:0];
endmodule

// ===== hdl/crc_datapath.sv =====
// Datapath: member store, running means, divider, CORDIC and result register.
module crc_datapath import crc_pkg::*; #(
   parameter int MAX_MEMBERS  = MAX_MEMBERS_DEF,
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  req_type req_word,
   input  cmd_type cmd,
   output sts_type sts,
   output rsp_type rsp_word
);
   localparam int ADW = $clog2(MAX_MEMBERS);
   localparam int CW  = $clog2(MAX_MEMBERS + 1);
   localparam int NW  = 32 + CW + 1;
   localparam int DNW = CW + 1;
   localparam int SW  = AW + CW + 1;   // weighted CORDIC sums

   req_type              r_ff;
   logic [CW-1:0]        count_ff;
   logic [15:0]          first_id_ff;
   logic signed [31:0]   mx_ff, my_ff, mz_ff;
   logic [15:0]          dwell_ff;
   logic signed [15:0]   head_ff;
   logic [1:0]           dsel_ff;   // which mean is being divided
   logic [ADW-1:0]       scan_ff;
   logic [CW-1:0]        scan_cnt_ff;
   logic signed [AW-1:0] c0_ff, s0_ff;
   logic signed [SW-1:0] sx_ff, sy_ff;
   logic signed [31:0]   fx_ff, fy_ff, fz_ff;
   logic signed [15:0]   fh_ff;
   logic                 hit_ff;
   rsp_type              rsp_ff;

   // member store
   logic [15:0]  mem_id   [MAX_MEMBERS];
   logic [95:0]  mem_pos  [MAX_MEMBERS];
   logic [15:0]  mem_head [MAX_MEMBERS];
   logic [15:0]  rd_id_ff;
   logic [95:0]  rd_pos_ff;
   logic [15:0]  rd_head_ff;
   logic         rd_vld_ff;

   // divider
   logic                 div_start;
   logic signed [NW-1:0] div_num;
   logic [DNW-1:0]       div_den;
   logic                 div_done;
   logic signed [NW-1:0] div_q;
   logic signed [31:0]   cur_mean;
   logic signed [31:0]   cur_pos;
   logic signed [NW-1:0] prod;

   // cordic
   logic                 cor_done;
   logic signed [AW-1:0] cor_c, cor_s;
   logic signed [15:0]   cor_ang;
   logic signed [15:0]   h_sat;
   logic signed [SW-1:0] wx, wy;

   always_comb begin
      case (dsel_ff)
         2'd0:    begin cur_mean = mx_ff; cur_pos = r_ff.item_x; end
         2'd1:    begin cur_mean = my_ff; cur_pos = r_ff.item_y; end
         2'd2:    begin cur_mean = mz_ff; cur_pos = r_ff.item_z; end
         default: begin cur_mean = 32'(dwell_ff); cur_pos = r_ff.item_dwell ? 32'sd32768 : 32'sd0; end
      endcase
      prod    = NW'($signed({1'b0, count_ff})) * NW'(cur_mean) + NW'(cur_pos);
      div_num = prod;
      div_den = DNW'(count_ff) + 1'b1;
      if (r_ff.item_orientation > HEAD_LIM)       h_sat = HEAD_LIM;
      else if (r_ff.item_orientation < -HEAD_LIM) h_sat = -HEAD_LIM;
      else                                        h_sat = r_ff.item_orientation;
      wx = SW'($signed({1'b0, count_ff})) * SW'(c0_ff) + SW'(cor_c);
      wy = SW'($signed({1'b0, count_ff})) * SW'(s0_ff) + SW'(cor_s);
   end

   assign div_start = cmd.div_start;

   crc_div #(.NW(NW), .DW(DNW)) u_div (
      .clock, .reset, .start(div_start), .dividend(div_num), .divisor(div_den),
      .done(div_done), .quotient(div_q)
   );

   crc_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
      .clock, .reset,
      .rot_start(cmd.rot_start),
      .heading(cmd.rot_sel ? r_ff.item_orientation : head_ff),
      .vec_start(cmd.vec_start),
      .vx(AW'(sx_ff)), .vy(AW'(sy_ff)),
      .done(cor_done), .cos_out(cor_c), .sin_out(cor_s), .angle(cor_ang)
   );

   always_ff @(posedge clock) begin
      if (cmd.store_wr) begin
         mem_id[count_ff[ADW-1:0]]   <= r_ff.item_id;
         mem_pos[count_ff[ADW-1:0]]  <= {r_ff.item_z, r_ff.item_y, r_ff.item_x};
         mem_head[count_ff[ADW-1:0]] <= r_ff.item_orientation;
      end
      rd_id_ff   <= mem_id[scan_ff];
      rd_pos_ff  <= mem_pos[scan_ff];
      rd_head_ff <= mem_head[scan_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         first_id_ff <= '0;
         mx_ff       <= '0;
         my_ff       <= '0;
         mz_ff       <= '0;
         dwell_ff    <= '0;
         head_ff     <= '0;
         dsel_ff     <= '0;
         scan_ff     <= '0;
         scan_cnt_ff <= '0;
         rd_vld_ff   <= 1'b0;
         hit_ff      <= 1'b0;
      end else begin
         rd_vld_ff <= cmd.scan_rd;
         if (cmd.load) begin
            dsel_ff <= '0;
            hit_ff  <= 1'b0;
         end
         if (cmd.scan_clr) begin
            scan_ff     <= '0;
            scan_cnt_ff <= '0;
         end else if (cmd.scan_rd) begin
            scan_ff     <= scan_ff + 1'b1;
            scan_cnt_ff <= scan_cnt_ff + 1'b1;
         end
         if (cmd.found_cap) hit_ff <= 1'b1;
         if (div_done) begin
            case (dsel_ff)
               2'd0:    mx_ff <= div_q[31:0];
               2'd1:    my_ff <= div_q[31:0];
               2'd2:    mz_ff <= div_q[31:0];
               default: dwell_ff <= div_q[15:0];
            endcase
            dsel_ff <= dsel_ff + 1'b1;
         end
         if (cmd.first_set) begin
            first_id_ff <= r_ff.item_id;
            mx_ff       <= r_ff.item_x;
            my_ff       <= r_ff.item_y;
            mz_ff       <= r_ff.item_z;
            dwell_ff    <= r_ff.item_dwell ? 16'h8000 : 16'h0000;
            head_ff     <= h_sat;
         end
         if (cmd.mean_upd) head_ff <= cor_ang;
         if (cmd.store_wr) count_ff <= count_ff + 1'b1;
         if (cmd.clear)    count_ff <= '0;
      end
      if (cmd.load) r_ff <= req_word;
      if (cmd.rot_start && !cmd.rot_sel) begin
         c0_ff <= '0;
         s0_ff <= '0;
      end
      // mean heading rotation ends as the new heading rotation starts
      if (cor_done && cmd.rot_start && cmd.rot_sel) begin
         c0_ff <= cor_c;
         s0_ff <= cor_s;
      end
      if (cmd.acc_load) begin
         sx_ff <= wx;
         sy_ff <= wy;
      end
      if (cmd.found_cap) begin
         fx_ff <= rd_pos_ff[31:0];
         fy_ff <= rd_pos_ff[63:32];
         fz_ff <= rd_pos_ff[95:64];
         fh_ff <= rd_head_ff;
      end
      if (cmd.rsp_load) begin
         rsp_ff.status           <= cmd.status;
         rsp_ff.member_count     <= 7'(count_ff);
         rsp_ff.cluster_id       <= first_id_ff;
         rsp_ff.mean_x           <= mx_ff;
         rsp_ff.mean_y           <= my_ff;
         rsp_ff.mean_z           <= mz_ff;
         rsp_ff.mean_dwell       <= dwell_ff;
         rsp_ff.mean_orientation <= head_ff;
         rsp_ff.found_x          <= hit_ff ? fx_ff : 32'sd0;
         rsp_ff.found_y          <= hit_ff ? fy_ff : 32'sd0;
         rsp_ff.found_z          <= hit_ff ? fz_ff : 32'sd0;
         rsp_ff.found_orientation <= hit_ff ? fh_ff : 16'sd0;
      end
   end

   always_comb begin
      sts.div_done   = div_done;
      sts.rot_done   = cor_done;
      sts.vec_done   = cor_done;
      sts.count_zero = (count_ff == '0);
      sts.full       = (count_ff == CW'(MAX_MEMBERS));
      sts.scan_end   = (scan_cnt_ff == count_ff);
      sts.id_match   = rd_vld_ff && (rd_id_ff == r_ff.item_id);
   end

   assign rsp_word = rsp_ff;

   a_store_room: assert property (@(posedge clock) disable iff (reset)
      cmd.store_wr |-> count_ff < CW'(MAX_MEMBERS)) else $error("store write when full");
   property p_count_bound;
      @(posedge clock) disable iff (reset) count_ff <= CW'(MAX_MEMBERS);
   endproperty
   a_count_bound: assert property (p_count_bound) else $error("count over capacity");
   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      cmd.clear |=> count_ff == '0) else $error("clear left members");
endmodule

// ===== hdl/crc_ctrl.sv =====
// Controller: sequences add, query and clear over the datapath.
module crc_ctrl import crc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic [1:0] req_op,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   input  sts_type sts,
   output cmd_type cmd
);
   typedef enum logic [10:0] {
      S_IDLE  = 11'b00000000001,
      S_DEC   = 11'b00000000010,
      S_DIV   = 11'b00000000100,
      S_ROT0  = 11'b00000001000,
      S_ROT1  = 11'b00000010000,
      S_ACC   = 11'b00000100000,
      S_VEC   = 11'b00001000000,
      S_SCAN  = 11'b00010000000,
      S_WAIT  = 11'b00100000000,
      S_RSP   = 11'b01000000000,
      S_OUT   = 11'b10000000000
   } state_type;

   state_type st_ff, st_in;
   op_type    op_ff;
   logic [1:0] status_ff, status_in;
   logic [1:0] ndiv_ff, ndiv_in;
   logic       rot_go_ff, rot_go_in;

   always_comb begin
      st_in     = st_ff;
      status_in = status_ff;
      ndiv_in   = ndiv_ff;
      rot_go_in = 1'b0;
      cmd       = '0;
      cmd.status = status_ff;
      req_ready = (st_ff == S_IDLE);
      rsp_valid = (st_ff == S_OUT);
      case (st_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load  = 1'b1;
               status_in = ST_DONE;
               st_in     = S_DEC;
            end
         end
         S_DEC: begin
            case (op_ff)
               OP_ADD: begin
                  if (sts.full) begin
                     status_in = ST_FULL;
                     st_in     = S_RSP;
                  end else if (sts.count_zero) begin
                     cmd.first_set = 1'b1;
                     cmd.store_wr  = 1'b1;
                     st_in         = S_RSP;
                  end else begin
                     cmd.div_start = 1'b1;
                     ndiv_in       = 2'd0;
                     st_in         = S_DIV;
                  end
               end
               OP_QUERY: begin
                  cmd.scan_clr = 1'b1;
                  st_in        = S_SCAN;
               end
               OP_CLEAR: begin
                  cmd.clear = 1'b1;
                  st_in     = S_RSP;
               end
               default: st_in = S_RSP;
            endcase
         end
         S_DIV: begin
            if (sts.div_done) begin
               if (ndiv_ff == 2'd3) begin
                  cmd.rot_start = 1'b1;
                  cmd.rot_sel   = 1'b0;
                  st_in         = S_ROT0;
               end else begin
                  ndiv_in = ndiv_ff + 1'b1;
                  rot_go_in = 1'b1;
               end
            end
            if (rot_go_ff) cmd.div_start = 1'b1;
         end
         S_ROT0: begin
            if (sts.rot_done) begin
               cmd.rot_start = 1'b1;
               cmd.rot_sel   = 1'b1;
               st_in         = S_ROT1;
            end
         end
         S_ROT1: begin
            cmd.rot_sel = 1'b1;
            if (sts.rot_done) begin
               cmd.acc_load = 1'b1;
               st_in        = S_ACC;
            end
         end
         S_ACC: begin
            cmd.vec_start = 1'b1;
            st_in         = S_VEC;
         end
         S_VEC: begin
            cmd.rot_sel = 1'b1;
            if (sts.vec_done) begin
               cmd.mean_upd = 1'b1;
               cmd.store_wr = 1'b1;
               st_in        = S_RSP;
            end
         end
         S_SCAN: begin
            if (sts.scan_end) st_in = S_WAIT;
            else              cmd.scan_rd = 1'b1;
            if (sts.id_match) begin
               cmd.found_cap = 1'b1;
               cmd.scan_rd   = 1'b0;
               status_in     = ST_FOUND;
               st_in         = S_RSP;
            end
         end
         S_WAIT: begin
            if (sts.id_match) begin
               cmd.found_cap = 1'b1;
               status_in     = ST_FOUND;
            end
            st_in = S_RSP;
         end
         S_RSP: begin
            cmd.rsp_load = 1'b1;
            st_in        = S_OUT;
         end
         S_OUT: begin
            if (rsp_ready) st_in = S_IDLE;
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff     <= S_IDLE;
         status_ff <= ST_DONE;
         ndiv_ff   <= '0;
         rot_go_ff <= 1'b0;
         op_ff     <= OP_NONE;
      end else begin
         st_ff     <= st_in;
         status_ff <= status_in;
         ndiv_ff   <= ndiv_in;
         rot_go_ff <= rot_go_in;
         if (cmd.load) op_ff <= op_type'(req_op);
      end
   end

   a_one_hot: assert property (@(posedge clock) disable iff (reset)
      $onehot(st_ff)) else $error("state not one-hot");
   a_rsp_after: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |=> rsp_valid) else $error("result not presented");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("accept while result pending");
endmodule

// ===== hdl/cluster_running_centroid_top.sv =====
// Top level: one cluster of tracked members with running means and circular mean heading.
// Clear, unknown op and first add go straight to the result; a query scans up to count_held (64 max) members;
//   a later add runs the shared bit-serial divider once per mean, then the shared CORDIC.
// Throughput: one word at a time; the next request is taken once the result is taken.
// Reset (synchronous, active high) empties the store and zeroes id and means;
//   member entries are not cleared and are only read below the fill count.
module cluster_running_centroid_top import crc_pkg::*; #(
   parameter int MAX_MEMBERS  = MAX_MEMBERS_DEF,
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input logic clock,
   input logic reset,
   crc_if.sink   req,
   crc_if.source rsp
);
   cmd_type cmd;
   sts_type sts;
   rsp_type rsp_word;

   // controller owns the handshake; datapath owns all payload
   crc_ctrl u_ctrl (
      .clock, .reset,
      .req_valid(req.valid), .req_op(req.data.operation), .req_ready(req.ready),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .sts, .cmd
   );

   crc_datapath #(.MAX_MEMBERS(MAX_MEMBERS), .CORDIC_STEPS(CORDIC_STEPS)) u_dp (
      .clock, .reset, .req_word(req.data), .cmd, .sts, .rsp_word
   );

   assign rsp.data = rsp_word;
endmodule
